// ===== sv/fat_cluster_chain_engine_top_assert.svh =====
// Assertion macros for the cluster chain engine top level.
`ifndef FAT_CLUSTER_CHAIN_ENGINE_TOP_ASSERT_SVH
`define FAT_CLUSTER_CHAIN_ENGINE_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define FCCE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define FCCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/fcce_pkg.sv =====
// Package: shared types, codes and widths of the cluster chain engine.
`timescale 1ns / 1ps
package fcce_pkg;

  localparam int CLUSTER_COUNT_DEF = 32;

  localparam int ENTRY_W   = 6;
  localparam int CLUSTER_W = 5;
  localparam int COUNT_W   = 5;
  localparam int FUNC_W    = 2;
  localparam int STATUS_W  = 2;

  // Link table entry codes
  localparam logic [ENTRY_W-1:0] FREE_MARK = 6'd0;
  localparam logic [ENTRY_W-1:0] END_MARK  = 6'd63;
  localparam logic [ENTRY_W-1:0] FIRST_USABLE = 6'd2;

  // Request functions
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WALK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [COUNT_W-1:0]   cluster_count;
    logic [CLUSTER_W-1:0] head_cluster;
  } fcce_req_t;

  typedef struct packed {
    logic [CLUSTER_W-1:0] cluster;
    logic [STATUS_W-1:0]  status;
    logic                 last;
  } fcce_rsp_t;

  // Source of the cluster number in a result
  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_SCAN,
    SEL_CUR,
    SEL_START
  } fcce_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic                load_alloc;
    logic                load_walk;
    logic                rd_scan;
    logic                rd_cur;
    logic                wr_end_scan;
    logic                wr_link_prev;
    logic                wr_free_cur;
    logic                scan_inc;
    logic                alloc_take;
    logic                walk_advance;
    logic                emit;
    fcce_sel_t           emit_sel;
    logic [STATUS_W-1:0] emit_status;
    logic                emit_last;
  } fcce_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic count_zero;
    logic start_bad;
    logic scan_end;
    logic steps_limit;
    logic rd_free;
    logic rd_end;
    logic rd_bad_link;
    logic remaining_one;
    logic have_prev;
    logic clear_mode;
  } fcce_stat_t;

endpackage

// ===== sv/fcce_datapath.sv =====
// Datapath: link table memory, scan and chain pointers, result register.
`timescale 1ns / 1ps
module fcce_datapath
  import fcce_pkg::*;
#(
  parameter int CLUSTER_COUNT = CLUSTER_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  fcce_req_t  req,
  input  fcce_cmd_t  cmd,
  output fcce_stat_t stat,
  output logic       result_valid,
  output fcce_rsp_t  rsp
);

  localparam int IDX_W  = $clog2(CLUSTER_COUNT);
  localparam int PTR_W  = $clog2(CLUSTER_COUNT + 1);
  localparam int STEP_W = $clog2(CLUSTER_COUNT - 1);
  localparam logic [ENTRY_W-1:0] N_ENTRY = ENTRY_W'(CLUSTER_COUNT);

  logic [ENTRY_W-1:0] mem [CLUSTER_COUNT];
  logic [CLUSTER_COUNT-1:0] valid;
  logic [ENTRY_W-1:0] rd_q;
  logic               rd_ok;
  logic [ENTRY_W-1:0] entry;

  logic [PTR_W-1:0]   scan;
  logic [IDX_W-1:0]   prev;
  logic               have_prev;
  logic [COUNT_W-1:0] remaining;
  logic [IDX_W-1:0]   cur;
  logic [STEP_W-1:0]  steps;
  logic               clear_mode;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] sel_val;

  // Never-written entries read as free
  assign entry = rd_ok ? rd_q : FREE_MARK;

  // Derive status for the controller
  always_comb begin
    stat.count_zero    = (req.cluster_count == '0);
    stat.start_bad     = (ENTRY_W'(req.head_cluster) < FIRST_USABLE) ||
                         (ENTRY_W'(req.head_cluster) >= N_ENTRY);
    stat.scan_end      = (scan >= PTR_W'(CLUSTER_COUNT));
    stat.steps_limit   = (steps >= STEP_W'(CLUSTER_COUNT - 2));
    stat.rd_free       = (entry == FREE_MARK);
    stat.rd_end        = (entry == END_MARK);
    stat.rd_bad_link   = (entry != FREE_MARK) && (entry != END_MARK) &&
                         ((entry < FIRST_USABLE) || (entry >= N_ENTRY));
    stat.remaining_one = (remaining == COUNT_W'(1));
    stat.have_prev     = have_prev;
    stat.clear_mode    = clear_mode;
  end

  // Select the single write of this cycle
  always_comb begin
    wr_en   = cmd.wr_link_prev | cmd.wr_end_scan | cmd.wr_free_cur;
    wr_addr = cur;
    wr_data = FREE_MARK;
    if (cmd.wr_link_prev) begin
      wr_addr = prev;
      wr_data = ENTRY_W'(scan);
    end else if (cmd.wr_end_scan) begin
      wr_addr = IDX_W'(scan);
      wr_data = END_MARK;
    end
  end

  assign rd_en   = cmd.rd_scan | cmd.rd_cur;
  assign rd_addr = cmd.rd_cur ? cur : IDX_W'(scan);

  // Link table storage with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      rd_ok <= valid[rd_addr];
    end
  end

  // Mark entries written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Hold and advance the allocation scan
  always_ff @(posedge clk) begin
    if (cmd.load_alloc) begin
      scan      <= PTR_W'(FIRST_USABLE);
      have_prev <= 1'b0;
      remaining <= req.cluster_count;
    end else begin
      if (cmd.scan_inc) begin
        scan <= scan + PTR_W'(1);
      end
      if (cmd.alloc_take) begin
        prev      <= IDX_W'(scan);
        have_prev <= 1'b1;
        remaining <= remaining - COUNT_W'(1);
      end
    end
  end

  // Hold and advance the chain walk
  always_ff @(posedge clk) begin
    if (cmd.load_walk) begin
      cur        <= IDX_W'(req.head_cluster);
      steps      <= '0;
      clear_mode <= (req.func == FUNC_FREE);
    end else if (cmd.walk_advance) begin
      cur   <= IDX_W'(entry);
      steps <= steps + STEP_W'(1);
    end
  end

  always_comb begin
    case (cmd.emit_sel)
      SEL_ZERO:  sel_val = '0;
      SEL_SCAN:  sel_val = ENTRY_W'(scan);
      SEL_CUR:   sel_val = ENTRY_W'(cur);
      SEL_START: sel_val = ENTRY_W'(req.head_cluster);
      default:   sel_val = '0;
    endcase
  end

  // Register the result transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.cluster <= sel_val[CLUSTER_W-1:0];
      rsp.status  <= cmd.emit_status;
      rsp.last    <= cmd.emit_last;
    end
  end

endmodule

// ===== sv/fcce_ctrl.sv =====
// Controller: sequences allocate, walk and free requests over the datapath.
`timescale 1ns / 1ps
module fcce_ctrl
  import fcce_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [FUNC_W-1:0] func,
  input  fcce_stat_t        stat,
  output fcce_cmd_t         cmd,
  output logic              busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_A_READ,
    S_A_CHECK,
    S_A_MARK,
    S_W_READ,
    S_W_CHECK
  } state_t;

  state_t state;
  state_t state_next;

  // Decode commands and the next state
  always_comb begin
    cmd         = '0;
    cmd.emit_sel    = SEL_ZERO;
    cmd.emit_status = ST_OK;
    state_next  = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (func)
            FUNC_ALLOC: begin
              if (!stat.count_zero) begin
                cmd.load_alloc = 1'b1;
                state_next     = S_A_READ;
              end
            end
            FUNC_WALK, FUNC_FREE: begin
              if (stat.start_bad) begin
                cmd.emit        = 1'b1;
                cmd.emit_sel    = SEL_START;
                cmd.emit_status = ST_BAD;
                cmd.emit_last   = 1'b1;
              end else begin
                cmd.load_walk = 1'b1;
                state_next    = S_W_READ;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_A_READ: begin
        if (stat.scan_end) begin
          cmd.emit        = 1'b1;
          cmd.emit_sel    = SEL_ZERO;
          cmd.emit_status = ST_FULL;
          cmd.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cmd.rd_scan = 1'b1;
          state_next  = S_A_CHECK;
        end
      end
      S_A_CHECK: begin
        if (stat.rd_free) begin
          cmd.wr_link_prev = stat.have_prev;
          cmd.emit         = 1'b1;
          cmd.emit_sel     = SEL_SCAN;
          cmd.emit_status  = ST_OK;
          cmd.emit_last    = stat.remaining_one;
          state_next       = S_A_MARK;
        end else begin
          cmd.scan_inc = 1'b1;
          state_next   = S_A_READ;
        end
      end
      S_A_MARK: begin
        cmd.wr_end_scan = 1'b1;
        cmd.alloc_take  = 1'b1;
        cmd.scan_inc    = 1'b1;
        state_next      = stat.remaining_one ? S_IDLE : S_A_READ;
      end
      S_W_READ: begin
        if (stat.steps_limit) begin
          cmd.emit        = 1'b1;
          cmd.emit_sel    = SEL_CUR;
          cmd.emit_status = ST_BAD;
          cmd.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cmd.rd_cur = 1'b1;
          state_next = S_W_CHECK;
        end
      end
      S_W_CHECK: begin
        cmd.wr_free_cur = stat.clear_mode;
        cmd.emit        = 1'b1;
        cmd.emit_sel    = SEL_CUR;
        if (stat.rd_free || stat.rd_end) begin
          cmd.emit_status = ST_OK;
          cmd.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end else if (stat.rd_bad_link) begin
          cmd.emit_status = ST_BAD;
          cmd.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cmd.emit_status  = ST_OK;
          cmd.walk_advance = 1'b1;
          state_next       = S_W_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state and the busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

// ===== sv/fat_cluster_chain_engine_top.sv =====
// Top level of the cluster chain engine: controller, datapath and checks.
//
//   channel   handshake               payload      direction
//   request   start / busy            req          in
//   result    result_valid (strobe)   rsp          out
//
// Allocate spends a read and a check state on each entry scanned, a mark state on
// each cluster taken and a read state on a disk-full result. Walk and free spend a
// read and a check state on each cluster visited and a read state on a too-long
// chain. Bad starts, zero counts and func 3 never raise busy.
// Reset is synchronous and frees every entry at once through per-entry valid
// bits, with no clearing pass. Results are one-cycle strobes; no stall exists.
`timescale 1ns / 1ps
`include "fat_cluster_chain_engine_top_assert.svh"
module fat_cluster_chain_engine_top
  import fcce_pkg::*;
#(
  parameter int CLUSTER_COUNT = CLUSTER_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  fcce_req_t req,
  output logic      result_valid,
  output fcce_rsp_t rsp
);

  fcce_cmd_t  cmd;
  fcce_stat_t stat;

  logic full_rsp;
  logic full_shape;
  logic mid_rsp;
  logic bad_start_req;
  logic bad_rsp;

  fcce_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .func (req.func),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  fcce_datapath #(
    .CLUSTER_COUNT(CLUSTER_COUNT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .cmd         (cmd),
    .stat        (stat),
    .result_valid(result_valid),
    .rsp         (rsp)
  );

  // Conditions watched by the checks
  assign full_rsp      = result_valid && (rsp.status == ST_FULL);
  assign full_shape    = (rsp.cluster == '0) && rsp.last;
  assign mid_rsp       = result_valid && !rsp.last;
  assign bad_start_req = start && !busy &&
                         ((req.func == FUNC_WALK) || (req.func == FUNC_FREE)) &&
                         (req.head_cluster < CLUSTER_W'(FIRST_USABLE));
  assign bad_rsp       = result_valid && (rsp.status == ST_BAD) && rsp.last;

  `FCCE_ASSERT_SAME(a_full_shape, full_rsp, full_shape, "disk-full result must be a final cluster 0")

  `FCCE_ASSERT_SAME(a_mid_busy, mid_rsp, busy, "non-final result seen while controller idle")

  `FCCE_ASSERT_NEXT(a_bad_start, bad_start_req, bad_rsp, "reserved start must give an error")

endmodule

// ===== dv/fat_cluster_chain_engine_top_test.sv =====
// Self-checking testbench for the cluster chain engine: directed table, then random requests.
`timescale 1ns / 1ps
module fat_cluster_chain_engine_top_test
  import fcce_pkg::*;
();

  localparam int TABLE_DEPTH = CLUSTER_COUNT_DEF;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int DIR_ROWS = 23;
  localparam int RANDOM_ITEMS = 355;
  localparam int CALM_TAIL = 60;
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT = 400000;

  // One row of the directed table; typed rows carry their own expectation
  typedef struct {
    fcce_req_t req;
    bit        typed;
    int        n_typed;
    fcce_rsp_t typed_rsp;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      start;
  logic      busy;
  fcce_req_t req;
  logic      result_valid;
  fcce_rsp_t rsp;

  // Shadow of the link table and the results still owed by the block
  logic [ENTRY_W-1:0]   fat_image [TABLE_DEPTH];
  fcce_rsp_t            chain_rsp [$];
  fcce_rsp_t            expected_rsp [$];
  logic [CLUSTER_W-1:0] chain_heads [$];
  plan_row_t            dir_plan [DIR_ROWS];
  fcce_rsp_t            want;
  int                   errors = 0;
  int                   cycle_count = 0;

  fat_cluster_chain_engine_top u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .result_valid (result_valid),
    .rsp          (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic fcce_rsp_t make_rsp(int cl, logic [STATUS_W-1:0] st, logic lst);
    fcce_rsp_t res;
    res.cluster = CLUSTER_W'(cl);
    res.status  = st;
    res.last    = lst;
    return res;
  endfunction

  // Apply one request to the shadow table and collect the results it causes
  function automatic void predict_chain(fcce_req_t r);
    int  prev;
    int  cur;
    int  nxt;
    int  steps;
    bit  clear;
    bit  done;
    chain_rsp.delete();
    case (r.func)
      FUNC_ALLOC: begin
        prev = -1;
        for (int k = 0; k < int'(r.cluster_count); k++) begin
          cur = -1;
          for (int i = int'(FIRST_USABLE); i < TABLE_DEPTH; i++) begin
            if (cur < 0 && fat_image[i] == FREE_MARK) cur = i;
          end
          // Out of space: earlier clusters stay linked
          if (cur < 0) begin
            chain_rsp.push_back(make_rsp(0, ST_FULL, 1'b1));
            return;
          end
          fat_image[cur] = END_MARK;
          if (prev >= 0) begin
            fat_image[prev] = ENTRY_W'(cur);
          end else begin
            chain_heads.push_back(CLUSTER_W'(cur));
            if (chain_heads.size() > 16) void'(chain_heads.pop_front());
          end
          chain_rsp.push_back(make_rsp(cur, ST_OK, k + 1 == int'(r.cluster_count)));
          prev = cur;
        end
      end
      FUNC_WALK, FUNC_FREE: begin
        clear = (r.func == FUNC_FREE);
        cur   = int'(r.head_cluster);
        if (cur < int'(FIRST_USABLE) || cur >= TABLE_DEPTH) begin
          chain_rsp.push_back(make_rsp(cur, ST_BAD, 1'b1));
          return;
        end
        steps = 0;
        done  = 1'b0;
        while (!done) begin
          if (steps >= TABLE_DEPTH - 2) begin
            // Chain too long: report without visiting
            chain_rsp.push_back(make_rsp(cur, ST_BAD, 1'b1));
            done = 1'b1;
          end else begin
            nxt = int'(fat_image[cur]);
            if (clear) fat_image[cur] = FREE_MARK;
            if (nxt == int'(END_MARK) || nxt == int'(FREE_MARK)) begin
              chain_rsp.push_back(make_rsp(cur, ST_OK, 1'b1));
              done = 1'b1;
            end else if (nxt < int'(FIRST_USABLE) || nxt >= TABLE_DEPTH) begin
              chain_rsp.push_back(make_rsp(cur, ST_BAD, 1'b1));
              done = 1'b1;
            end else begin
              chain_rsp.push_back(make_rsp(cur, ST_OK, 1'b0));
              cur = nxt;
              steps++;
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Present one transaction, optionally after an idle burst, and book its results
  task automatic send_request(fcce_req_t r, bit typed, int n_typed, fcce_rsp_t typed_rsp,
                              bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    predict_chain(r);
    if (typed) begin
      if (n_typed > 0) expected_rsp.push_back(typed_rsp);
    end else begin
      foreach (chain_rsp[i]) expected_rsp.push_back(chain_rsp[i]);
    end
  endtask

  // Check each result strobe against the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected result cluster=%0d status=%0d last=%0d",
                 $time, rsp.cluster, rsp.status, rsp.last);
        errors++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.cluster !== want.cluster || rsp.status !== want.status ||
            rsp.last !== want.last) begin
          $display("%0t: mismatch expected %0d/%0d/%0d got %0d/%0d/%0d (cluster/status/last)",
                   $time, want.cluster, want.status, want.last,
                   rsp.cluster, rsp.status, rsp.last);
          errors++;
        end
      end
    end
  end

  initial begin
    fcce_req_t r;
    int        pick;
    rst   <= 1'b1;
    start <= 1'b0;
    req   <= '0;
    for (int i = 0; i < TABLE_DEPTH; i++) fat_image[i] = FREE_MARK;
    fat_image[0] = END_MARK;
    fat_image[1] = END_MARK;

    dir_plan = '{
      // bad starts and walks of free entries on an empty table
      '{'{FUNC_WALK,   5'd0,  5'd0},  1'b1, 1, '{5'd0,  ST_BAD, 1'b1}},
      '{'{FUNC_FREE,   5'd0,  5'd1},  1'b1, 1, '{5'd1,  ST_BAD, 1'b1}},
      '{'{FUNC_WALK,   5'd0,  5'd31}, 1'b1, 1, '{5'd31, ST_OK,  1'b1}},
      '{'{FUNC_FREE,   5'd31, 5'd31}, 1'b1, 1, '{5'd31, ST_OK,  1'b1}},
      // requests that cause nothing
      '{'{FUNC_ALLOC,  5'd0,  5'd0},  1'b1, 0, '0},
      '{'{FUNC_UNUSED, 5'd31, 5'd31}, 1'b1, 0, '0},
      // fill the table, then overflow it
      '{'{FUNC_ALLOC,  5'd1,  5'd0},  1'b1, 1, '{5'd2,  ST_OK,  1'b1}},
      '{'{FUNC_ALLOC,  5'd30, 5'd31}, 1'b0, 0, '0},
      '{'{FUNC_WALK,   5'd0,  5'd3},  1'b0, 0, '0},
      '{'{FUNC_ALLOC,  5'd1,  5'd0},  1'b1, 1, '{5'd0,  ST_FULL, 1'b1}},
      '{'{FUNC_FREE,   5'd0,  5'd2},  1'b1, 1, '{5'd2,  ST_OK,  1'b1}},
      '{'{FUNC_FREE,   5'd0,  5'd3},  1'b0, 0, '0},
      // longest chain, beyond the table size
      '{'{FUNC_ALLOC,  5'd31, 5'd0},  1'b0, 0, '0},
      '{'{FUNC_WALK,   5'd0,  5'd2},  1'b0, 0, '0},
      '{'{FUNC_FREE,   5'd0,  5'd2},  1'b0, 0, '0},
      // fragment the table and reuse a freed tail
      '{'{FUNC_ALLOC,  5'd5,  5'd0},  1'b0, 0, '0},
      '{'{FUNC_ALLOC,  5'd5,  5'd0},  1'b0, 0, '0},
      '{'{FUNC_FREE,   5'd0,  5'd4},  1'b0, 0, '0},
      '{'{FUNC_ALLOC,  5'd2,  5'd0},  1'b0, 0, '0},
      '{'{FUNC_WALK,   5'd0,  5'd2},  1'b0, 0, '0},
      '{'{FUNC_FREE,   5'd0,  5'd7},  1'b0, 0, '0},
      '{'{FUNC_WALK,   5'd0,  5'd30}, 1'b1, 1, '{5'd30, ST_OK,  1'b1}},
      '{'{FUNC_FREE,   5'd0,  5'd2},  1'b0, 0, '0}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_request(dir_plan[i].req, dir_plan[i].typed, dir_plan[i].n_typed,
                   dir_plan[i].typed_rsp, 1'b1);
    end

    // Random part: mostly short allocations and walks or frees of known chains
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick            = $urandom_range(0, 99);
      r.cluster_count = COUNT_W'($urandom_range(1, 8));
      if ($urandom_range(0, 9) == 0) r.cluster_count = COUNT_W'($urandom_range(0, 31));
      r.head_cluster  = CLUSTER_W'($urandom_range(0, 31));
      if (pick < 40) begin
        r.func = FUNC_ALLOC;
      end else if (pick < 95) begin
        r.func = (pick < 70) ? FUNC_WALK : FUNC_FREE;
        if (chain_heads.size() > 0 && $urandom_range(0, 3) != 0) begin
          r.head_cluster = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
        end
      end else begin
        r.func = FUNC_UNUSED;
      end

      // Hold off once until the block has delivered everything
      if (n == RANDOM_ITEMS / 2) begin
        start <= 1'b0;
        do @(posedge clk); while (expected_rsp.size() != 0 || busy);
      end

      send_request(r, 1'b0, 0, '0, n < RANDOM_ITEMS - CALM_TAIL);
    end

    // Drain, then allow for trailing strobes
    start <= 1'b0;
    do @(posedge clk); while (expected_rsp.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== fat_cluster_chain_engine_top.f =====
+incdir+sv
sv/fcce_pkg.sv
sv/fcce_datapath.sv
sv/fcce_ctrl.sv
sv/fat_cluster_chain_engine_top.sv
dv/fat_cluster_chain_engine_top_test.sv
